// ----- src/rgbhsv_pkg.sv -----
// rgbhsv_pkg: widths, hue sector codes and constant-multiply helpers
// for the rgb to hsv pixel converter; no dependencies
package rgbhsv_pkg;

    // channel and result widths
    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int NUM_W   = 15;   // numerators 60*n and 100*d stay below 2**15
    localparam int N_W     = 9;    // hue numerator term n, up to 2*d
    localparam int QUO_W   = 7;    // both quotients stay below 128
    localparam int DIV_STAGES = QUO_W;

    // hue sector bases in degrees
    localparam logic [HUE_W-1:0] BASE_RED_UP   = 9'd0;
    localparam logic [HUE_W-1:0] BASE_RED_WRAP = 9'd300;
    localparam logic [HUE_W-1:0] BASE_GREEN    = 9'd60;
    localparam logic [HUE_W-1:0] BASE_BLUE     = 9'd180;

    // hue sector, picked by which channel is the max and, for a red max, by green against blue
    typedef enum logic [1:0] {
        SEC_RED_UP,
        SEC_RED_WRAP,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // 60 * n by shift and subtract
    function automatic logic [NUM_W-1:0] mul60(input logic [N_W-1:0] n);
        logic [NUM_W-1:0] x;
        begin
            x = NUM_W'(n);
            mul60 = (x << 6) - (x << 2);
        end
    endfunction

    // 100 * x by shift and add
    function automatic logic [NUM_W-1:0] mul100(input logic [CHAN_W-1:0] v);
        logic [NUM_W-1:0] x;
        begin
            x = NUM_W'(v);
            mul100 = (x << 6) + (x << 5) + (x << 2);
        end
    endfunction

endpackage

// ----- src/rgb_to_hsv_converter.sv -----
// rgb_to_hsv_converter: pipelined rgb to hsv pixel conversion
// depends on rgbhsv_pkg
//
// usage
//   s_* channel takes one pixel item: tdata = red, green, blue (8 bits each)
//   m_* channel gives one result item per pixel: hue in degrees (0..359),
//   saturation and brightness in percent (0..100), all rounded down
//   the pipeline has 11 register stages: three of max/min, sector and
//   numerator logic, seven restoring divide stages (one quotient bit
//   each, hue and saturation dividers side by side) and the output
//   register that adds the hue base
//   throughput is one item per cycle while the output is not blocked;
//   every stage holds a valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and the input keeps
//   accepting while a result waits
//   when m_tready is low the items back up stage by stage; nothing is
//   lost or repeated, and s_tready drops only once every stage is full
//   grey pixels give hue 0, black pixels give saturation 0
//   reset clears all valid bits; the pipeline is empty after reset
module rgb_to_hsv_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hue [8:0], saturation [15:9], brightness [22:16]
);

    localparam int DS = rgbhsv_pkg::DIV_STAGES;

    // stage 1: channels, max, min and sector
    logic                                v1_reg;
    logic [rgbhsv_pkg::CHAN_W-1:0]       r1_reg, g1_reg, b1_reg, mx1_reg, mn1_reg;
    rgbhsv_pkg::sector_t                 sec1_reg;

    // stage 2: difference, hue term and base
    logic                                v2_reg;
    logic [rgbhsv_pkg::CHAN_W-1:0]       d2_reg, mx2_reg;
    logic [rgbhsv_pkg::N_W-1:0]          n2_reg;
    logic [rgbhsv_pkg::HUE_W-1:0]        base2_reg;

    // stage 3: numerators, brightness and zero flags
    logic                                v3_reg;
    logic [rgbhsv_pkg::NUM_W-1:0]        hnum3_reg, snum3_reg;
    logic [rgbhsv_pkg::CHAN_W-1:0]       hden3_reg, sden3_reg;
    logic [rgbhsv_pkg::HUE_W-1:0]        base3_reg;
    logic                                hz3_reg, sz3_reg;
    logic [rgbhsv_pkg::PCT_W-1:0]        br3_reg;

    // divide stages
    logic                                dv_reg   [DS];
    logic [rgbhsv_pkg::NUM_W-1:0]        hrem_reg [DS];
    logic [rgbhsv_pkg::NUM_W-1:0]        srem_reg [DS];
    logic [rgbhsv_pkg::QUO_W-1:0]        hq_reg   [DS];
    logic [rgbhsv_pkg::QUO_W-1:0]        sq_reg   [DS];
    logic [rgbhsv_pkg::CHAN_W-1:0]       hden_reg [DS];
    logic [rgbhsv_pkg::CHAN_W-1:0]       sden_reg [DS];
    logic [rgbhsv_pkg::HUE_W-1:0]        base_reg [DS];
    logic                                hz_reg   [DS];
    logic                                sz_reg   [DS];
    logic [rgbhsv_pkg::PCT_W-1:0]        br_reg   [DS];

    // output register
    logic                                ov_reg;
    logic [rgbhsv_pkg::HUE_W-1:0]        hue_reg;
    logic [rgbhsv_pkg::PCT_W-1:0]        sat_reg, bri_reg;

    // stage ready chain, built back from the output
    logic rdy_out, rdy3, rdy2, rdy1;
    logic rdy_d [DS];

    always_comb
    begin
        rdy_out       = !ov_reg || m_tready;
        rdy_d[DS-1]   = !dv_reg[DS-1] || rdy_out;
        for (int j = DS - 2; j >= 0; j--)
            rdy_d[j] = !dv_reg[j] || rdy_d[j+1];
        rdy3 = !v3_reg || rdy_d[0];
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
    end

    assign s_tready = rdy1;

    // stage 1 next values: max, min and sector by red, green, blue priority
    logic [rgbhsv_pkg::CHAN_W-1:0] in_r, in_g, in_b;
    logic [rgbhsv_pkg::CHAN_W-1:0] mx1_next, mn1_next;
    rgbhsv_pkg::sector_t           sec1_next;

    always_comb
    begin
        in_r = s_tdata[7:0];
        in_g = s_tdata[15:8];
        in_b = s_tdata[23:16];
        mx1_next = in_r;
        mn1_next = in_r;
        if (in_g > mx1_next) mx1_next = in_g;
        if (in_b > mx1_next) mx1_next = in_b;
        if (in_g < mn1_next) mn1_next = in_g;
        if (in_b < mn1_next) mn1_next = in_b;
        if (mx1_next == in_r)
            sec1_next = (in_g >= in_b) ? rgbhsv_pkg::SEC_RED_UP : rgbhsv_pkg::SEC_RED_WRAP;
        else if (mx1_next == in_g)
            sec1_next = rgbhsv_pkg::SEC_GREEN;
        else
            sec1_next = rgbhsv_pkg::SEC_BLUE;
    end

    // stage 2 next values: d = max - min, sector term n and base
    logic [rgbhsv_pkg::CHAN_W-1:0] d2_next;
    logic [rgbhsv_pkg::N_W-1:0]    n2_next;
    logic [rgbhsv_pkg::HUE_W-1:0]  base2_next;

    always_comb
    begin
        d2_next = mx1_reg - mn1_reg;
        unique case (sec1_reg)
            rgbhsv_pkg::SEC_RED_UP:
            begin
                n2_next    = rgbhsv_pkg::N_W'(g1_reg) - rgbhsv_pkg::N_W'(b1_reg);
                base2_next = rgbhsv_pkg::BASE_RED_UP;
            end
            rgbhsv_pkg::SEC_RED_WRAP:
            begin
                n2_next    = rgbhsv_pkg::N_W'(g1_reg) + rgbhsv_pkg::N_W'(d2_next)
                           - rgbhsv_pkg::N_W'(b1_reg);
                base2_next = rgbhsv_pkg::BASE_RED_WRAP;
            end
            rgbhsv_pkg::SEC_GREEN:
            begin
                n2_next    = rgbhsv_pkg::N_W'(b1_reg) + rgbhsv_pkg::N_W'(d2_next)
                           - rgbhsv_pkg::N_W'(r1_reg);
                base2_next = rgbhsv_pkg::BASE_GREEN;
            end
            rgbhsv_pkg::SEC_BLUE:
            begin
                n2_next    = rgbhsv_pkg::N_W'(r1_reg) + rgbhsv_pkg::N_W'(d2_next)
                           - rgbhsv_pkg::N_W'(g1_reg);
                base2_next = rgbhsv_pkg::BASE_BLUE;
            end
            default:
            begin
                n2_next    = '0;
                base2_next = rgbhsv_pkg::BASE_RED_UP;
            end
        endcase
    end

    // stage 3 next values: numerators and brightness = floor(100*max/255)
    // x/256 undershoots x/255 by less than one, so one correction step
    logic [rgbhsv_pkg::NUM_W-1:0] bx3;
    logic [rgbhsv_pkg::PCT_W-1:0] bq3;
    logic [8:0]                   brem3;
    logic [rgbhsv_pkg::PCT_W-1:0] br3_next;

    always_comb
    begin
        bx3      = rgbhsv_pkg::mul100(mx2_reg);
        bq3      = bx3[14:8];
        brem3    = {1'b0, bx3[7:0]} + {2'b00, bq3};
        br3_next = (brem3 >= 9'd255) ? bq3 + 7'd1 : bq3;
    end

    // restoring divide, one quotient bit per stage, msb first
    logic [rgbhsv_pkg::NUM_W-1:0] hrem_in [DS];
    logic [rgbhsv_pkg::NUM_W-1:0] srem_in [DS];
    logic [rgbhsv_pkg::QUO_W-1:0] hq_in   [DS];
    logic [rgbhsv_pkg::QUO_W-1:0] sq_in   [DS];
    logic [rgbhsv_pkg::CHAN_W-1:0] hden_in [DS];
    logic [rgbhsv_pkg::CHAN_W-1:0] sden_in [DS];
    logic [rgbhsv_pkg::NUM_W-1:0] hsh     [DS];
    logic [rgbhsv_pkg::NUM_W-1:0] ssh     [DS];
    logic [rgbhsv_pkg::NUM_W-1:0] hrem_next [DS];
    logic [rgbhsv_pkg::NUM_W-1:0] srem_next [DS];
    logic [rgbhsv_pkg::QUO_W-1:0] hq_next   [DS];
    logic [rgbhsv_pkg::QUO_W-1:0] sq_next   [DS];

    always_comb
    begin
        // first divide stage takes the numerators from stage 3
        hrem_in[0] = hnum3_reg;
        srem_in[0] = snum3_reg;
        hq_in[0]   = '0;
        sq_in[0]   = '0;
        hden_in[0] = hden3_reg;
        sden_in[0] = sden3_reg;
        for (int j = 1; j < DS; j++)
        begin
            hrem_in[j] = hrem_reg[j-1];
            srem_in[j] = srem_reg[j-1];
            hq_in[j]   = hq_reg[j-1];
            sq_in[j]   = sq_reg[j-1];
            hden_in[j] = hden_reg[j-1];
            sden_in[j] = sden_reg[j-1];
        end
        for (int j = 0; j < DS; j++)
        begin
            hsh[j] = rgbhsv_pkg::NUM_W'(hden_in[j]) << (DS - 1 - j);
            ssh[j] = rgbhsv_pkg::NUM_W'(sden_in[j]) << (DS - 1 - j);
            if (hrem_in[j] >= hsh[j])
            begin
                hrem_next[j] = hrem_in[j] - hsh[j];
                hq_next[j]   = hq_in[j] | (rgbhsv_pkg::QUO_W'(1) << (DS - 1 - j));
            end
            else
            begin
                hrem_next[j] = hrem_in[j];
                hq_next[j]   = hq_in[j];
            end
            if (srem_in[j] >= ssh[j])
            begin
                srem_next[j] = srem_in[j] - ssh[j];
                sq_next[j]   = sq_in[j] | (rgbhsv_pkg::QUO_W'(1) << (DS - 1 - j));
            end
            else
            begin
                srem_next[j] = srem_in[j];
                sq_next[j]   = sq_in[j];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int j = 0; j < DS; j++)
                dv_reg[j] <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy_d[0]) dv_reg[0] <= v3_reg;
            for (int j = 1; j < DS; j++)
            begin
                if (rdy_d[j])
                    dv_reg[j] <= dv_reg[j-1];
            end
            if (rdy_out) ov_reg <= dv_reg[DS-1];
        end
    end

    // front stages payload
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            r1_reg   <= in_r;
            g1_reg   <= in_g;
            b1_reg   <= in_b;
            mx1_reg  <= mx1_next;
            mn1_reg  <= mn1_next;
            sec1_reg <= sec1_next;
        end
        if (rdy2)
        begin
            d2_reg    <= d2_next;
            mx2_reg   <= mx1_reg;
            n2_reg    <= n2_next;
            base2_reg <= base2_next;
        end
        if (rdy3)
        begin
            hnum3_reg <= rgbhsv_pkg::mul60(n2_reg);
            snum3_reg <= rgbhsv_pkg::mul100(d2_reg);
            hden3_reg <= d2_reg;
            sden3_reg <= mx2_reg;
            base3_reg <= base2_reg;
            hz3_reg   <= (d2_reg == '0);
            sz3_reg   <= (mx2_reg == '0);
            br3_reg   <= br3_next;
        end
    end

    // divide stages payload
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DS; j++)
        begin
            if (rdy_d[j])
            begin
                hrem_reg[j] <= hrem_next[j];
                srem_reg[j] <= srem_next[j];
                hq_reg[j]   <= hq_next[j];
                sq_reg[j]   <= sq_next[j];
                hden_reg[j] <= hden_in[j];
                sden_reg[j] <= sden_in[j];
            end
        end
        if (rdy_d[0])
        begin
            base_reg[0] <= base3_reg;
            hz_reg[0]   <= hz3_reg;
            sz_reg[0]   <= sz3_reg;
            br_reg[0]   <= br3_reg;
        end
        for (int j = 1; j < DS; j++)
        begin
            if (rdy_d[j])
            begin
                base_reg[j] <= base_reg[j-1];
                hz_reg[j]   <= hz_reg[j-1];
                sz_reg[j]   <= sz_reg[j-1];
                br_reg[j]   <= br_reg[j-1];
            end
        end
    end

    // output register: add sector base, force grey and black cases
    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            hue_reg <= hz_reg[DS-1] ? '0
                     : base_reg[DS-1] + rgbhsv_pkg::HUE_W'(hq_reg[DS-1]);
            sat_reg <= sz_reg[DS-1] ? '0 : sq_reg[DS-1];
            bri_reg <= br_reg[DS-1];
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, bri_reg, sat_reg, hue_reg};

`ifndef SYNTHESIS
    // hue stays below a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (hue_reg < 9'd360))
        else $error("hue out of range");

    // percentages stay within 0..100
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (sat_reg <= 7'd100) && (bri_reg <= 7'd100))
        else $error("percentage out of range");

    // input stalls only when the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (ov_reg && !m_tready))
        else $error("input stalled with output free");

    // a blocked result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_tready) |=> $stable(m_tdata))
        else $error("stalled result changed");
`endif

endmodule
